// ----- hw/rtl/rump_pkg.sv -----
`default_nettype none
package rump_pkg;

  localparam int unsigned MaxAsPathDefault = 64;
  localparam int unsigned HdrBytes = 19;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [3:0] {
    KIND_WITHDRAWN = 4'd0,
    KIND_ORIGIN    = 4'd1,
    KIND_AS_ELEM   = 4'd2,
    KIND_NEXT_HOP  = 4'd3,
    KIND_MED       = 4'd4,
    KIND_LOCAL_PREF = 4'd5,
    KIND_ANNOUNCED = 4'd6,
    KIND_OVERFLOW  = 4'd7,
    KIND_BAD_LEN   = 4'd8,
    KIND_END       = 4'd9
  } rec_kind_e;

  typedef enum logic [3:0] {
    SEC_HDR       = 4'd0,
    SEC_WLEN_HI   = 4'd1,
    SEC_WLEN_LO   = 4'd2,
    SEC_WDR_LEN   = 4'd3,
    SEC_WDR_BYTES = 4'd4,
    SEC_ALEN_HI   = 4'd5,
    SEC_ALEN_LO   = 4'd6,
    SEC_ATTR_FLAGS = 4'd7,
    SEC_ATTR_TYPE = 4'd8,
    SEC_ATTR_LEN_HI = 4'd9,
    SEC_ATTR_LEN_LO = 4'd10,
    SEC_ATTR_VALUE = 4'd11,
    SEC_NLRI_LEN  = 4'd12,
    SEC_NLRI_BYTES = 4'd13,
    SEC_IDLE      = 4'd14
  } section_e;

  localparam logic [7:0] AttrOrigin = 8'd1;
  localparam logic [7:0] AttrAsPath = 8'd2;
  localparam logic [7:0] AttrNextHop = 8'd3;
  localparam logic [7:0] AttrLocalPref = 8'd5;
  localparam logic [7:0] SegAsSequence = 8'd2;

  typedef struct packed {
    logic [3:0]  rec_kind;
    logic [5:0]  prefix_bits;
    logic [31:0] field_value;
    logic [5:0]  path_index;
  } rec_t;

  typedef struct packed {
    logic a_vld;
    rec_t a;
    logic b_vld;
    rec_t b;
  } pair_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rump_if.sv -----
`default_nettype none
interface rump_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       end_of_message;
  modport source (output valid, output msg_byte, output end_of_message, input ready);
  modport sink (input valid, input msg_byte, input end_of_message, output ready);
endinterface

interface rump_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  rec_kind;
  logic [5:0]  prefix_bits;
  logic [31:0] field_value;
  logic [5:0]  path_index;
  logic        last_of_run;
  modport source (output valid, output rec_kind, output prefix_bits, output field_value,
                  output path_index, output last_of_run, input ready);
  modport sink (input valid, input rec_kind, input prefix_bits, input field_value,
                input path_index, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rump_front.sv -----
`default_nettype none
module rump_front #(
  parameter int unsigned MaxAsPath = rump_pkg::MaxAsPathDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           four_octet_as_i,
  input  wire logic           step_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           eom_i,
  output rump_pkg::pair_t     pair_o
);
  import rump_pkg::*;

  localparam int unsigned CntW = $clog2(MaxAsPath + 1);

  section_e    sec_q, sec_d;
  logic [4:0]  pos_q, pos_d;
  logic [15:0] srem_q, srem_d;
  logic [7:0]  atype_q, atype_d;
  logic        long_len_q, long_len_d;
  logic [15:0] arem_q, arem_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  fbl_q, fbl_d;
  logic [5:0]  plen_q, plen_d;
  logic [7:0]  seg_left_q, seg_left_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic [1:0]  phase_q, phase_d;
  logic        is_seq_q, is_seq_d;

  rec_t        ra, rb;
  logic        ra_v;
  logic [15:0] srem_dec;
  logic [2:0]  fbl_dec;
  logic [31:0] acc_sh;
  logic [2:0]  as_w;
  logic [15:0] arem_dec;

  function automatic rec_t mk(rec_kind_e k, logic [5:0] bits, logic [31:0] v,
                              logic [5:0] idx);
    rec_t r;
    r.rec_kind = k;
    r.prefix_bits = bits;
    r.field_value = v;
    r.path_index = idx;
    return r;
  endfunction

  function automatic logic [31:0] align(logic [31:0] v, logic [5:0] len);
    logic [2:0] nb;
    nb = 3'((7'(len) + 7'd7) >> 3);
    case (nb)
      3'd1:    return {v[7:0], 24'd0};
      3'd2:    return {v[15:0], 16'd0};
      3'd3:    return {v[23:0], 8'd0};
      3'd4:    return v;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    srem_dec = (srem_q != 16'd0) ? srem_q - 16'd1 : srem_q;
    fbl_dec = (fbl_q != 3'd0) ? fbl_q - 3'd1 : fbl_q;
    acc_sh = {acc_q[23:0], byte_i};
    as_w = four_octet_as_i ? 3'd4 : 3'd2;
    arem_dec = arem_q - 16'd1;
  end

  always_comb begin
    sec_d = sec_q; pos_d = pos_q; srem_d = srem_q; atype_d = atype_q;
    long_len_d = long_len_q; arem_d = arem_q; acc_d = acc_q; fbl_d = fbl_q;
    plen_d = plen_q; seg_left_d = seg_left_q; cnt_d = cnt_q; ovf_d = ovf_q;
    phase_d = phase_q; is_seq_d = is_seq_q;
    ra_v = 1'b0;
    ra = mk(KIND_END, '0, '0, '0);
    case (sec_q)
      SEC_HDR: begin
        pos_d = pos_q + 5'd1;
        if (pos_q >= 5'(HdrBytes - 1)) sec_d = SEC_WLEN_HI;
      end
      SEC_WLEN_HI, SEC_ALEN_HI: begin
        srem_d = {byte_i, 8'd0};
        sec_d = (sec_q == SEC_WLEN_HI) ? SEC_WLEN_LO : SEC_ALEN_LO;
      end
      SEC_WLEN_LO: begin
        srem_d = {srem_q[15:8], byte_i};
        sec_d = (srem_d != 16'd0) ? SEC_WDR_LEN : SEC_ALEN_HI;
      end
      SEC_ALEN_LO: begin
        srem_d = {srem_q[15:8], byte_i};
        sec_d = (srem_d != 16'd0) ? SEC_ATTR_FLAGS : SEC_NLRI_LEN;
      end
      SEC_WDR_LEN, SEC_NLRI_LEN: begin
        if (sec_q == SEC_WDR_LEN) srem_d = srem_dec;
        if (byte_i > 8'd32) begin
          sec_d = SEC_IDLE;
          ra_v = 1'b1;
          ra = mk(KIND_BAD_LEN, '0, {24'd0, byte_i}, '0);
        end else begin
          plen_d = byte_i[5:0];
          acc_d = '0;
          fbl_d = 3'((byte_i + 8'd7) >> 3);
          if (byte_i == 8'd0) begin
            ra_v = 1'b1;
            ra = mk((sec_q == SEC_WDR_LEN) ? KIND_WITHDRAWN : KIND_ANNOUNCED,
                    6'd0, '0, '0);
            if (sec_q == SEC_WDR_LEN)
              sec_d = (srem_d == 16'd0) ? SEC_ALEN_HI : SEC_WDR_LEN;
          end else begin
            sec_d = (sec_q == SEC_WDR_LEN) ? SEC_WDR_BYTES : SEC_NLRI_BYTES;
          end
        end
      end
      SEC_WDR_BYTES, SEC_NLRI_BYTES: begin
        if (sec_q == SEC_WDR_BYTES) srem_d = srem_dec;
        acc_d = acc_sh;
        fbl_d = fbl_dec;
        if (fbl_dec == 3'd0) begin
          ra_v = 1'b1;
          ra = mk((sec_q == SEC_WDR_BYTES) ? KIND_WITHDRAWN : KIND_ANNOUNCED,
                  plen_q, align(acc_sh, plen_q), '0);
          if (sec_q == SEC_WDR_BYTES)
            sec_d = (srem_d == 16'd0) ? SEC_ALEN_HI : SEC_WDR_LEN;
          else
            sec_d = SEC_NLRI_LEN;
        end
      end
      SEC_ATTR_FLAGS: begin
        srem_d = srem_dec;
        long_len_d = byte_i[4];
        sec_d = SEC_ATTR_TYPE;
      end
      SEC_ATTR_TYPE: begin
        srem_d = srem_dec;
        atype_d = byte_i;
        arem_d = '0;
        sec_d = long_len_q ? SEC_ATTR_LEN_HI : SEC_ATTR_LEN_LO;
      end
      SEC_ATTR_LEN_HI: begin
        srem_d = srem_dec;
        arem_d = {byte_i, 8'd0};
        sec_d = SEC_ATTR_LEN_LO;
      end
      SEC_ATTR_LEN_LO: begin
        srem_d = srem_dec;
        arem_d = {arem_q[15:8], byte_i};
        acc_d = '0;
        phase_d = 2'd0;
        seg_left_d = '0;
        if (atype_q == AttrOrigin) fbl_d = 3'd1;
        else if (atype_q >= AttrNextHop && atype_q <= AttrLocalPref) fbl_d = 3'd4;
        else fbl_d = 3'd0;
        if (arem_d == 16'd0)
          sec_d = (srem_d != 16'd0) ? SEC_ATTR_FLAGS : SEC_NLRI_LEN;
        else
          sec_d = SEC_ATTR_VALUE;
      end
      SEC_ATTR_VALUE: begin
        srem_d = srem_dec;
        arem_d = arem_dec;
        if (atype_q == AttrOrigin) begin
          if (fbl_q != 3'd0) begin
            fbl_d = 3'd0;
            ra_v = 1'b1;
            ra = mk(KIND_ORIGIN, '0, {24'd0, byte_i}, '0);
          end
        end else if (atype_q == AttrAsPath) begin
          case (phase_q)
            2'd0: begin
              is_seq_d = (byte_i == SegAsSequence);
              phase_d = 2'd1;
            end
            2'd1: begin
              seg_left_d = byte_i;
              if (byte_i != 8'd0) begin
                phase_d = 2'd2;
                fbl_d = as_w;
                acc_d = '0;
              end else begin
                phase_d = 2'd0;
              end
            end
            default: begin
              acc_d = acc_sh;
              fbl_d = fbl_dec;
              if (fbl_dec == 3'd0) begin
                if (is_seq_q) begin
                  if (32'(cnt_q) < MaxAsPath) begin
                    ra_v = 1'b1;
                    ra = mk(KIND_AS_ELEM, '0, acc_sh, 6'(cnt_q));
                    cnt_d = cnt_q + 1'b1;
                  end else if (!ovf_q) begin
                    ovf_d = 1'b1;
                    ra_v = 1'b1;
                    ra = mk(KIND_OVERFLOW, '0, acc_sh, '0);
                  end
                end
                seg_left_d = seg_left_q - 8'd1;
                acc_d = '0;
                if (seg_left_d == 8'd0) phase_d = 2'd0;
                else fbl_d = as_w;
              end
            end
          endcase
        end else if (atype_q >= AttrNextHop && atype_q <= AttrLocalPref) begin
          if (fbl_q != 3'd0) begin
            acc_d = acc_sh;
            fbl_d = fbl_dec;
            if (fbl_dec == 3'd0) begin
              ra_v = 1'b1;
              ra = mk(rec_kind_e'(atype_q[3:0]), '0, acc_sh, '0);
            end
          end
        end
        if (arem_dec == 16'd0)
          sec_d = (srem_d != 16'd0) ? SEC_ATTR_FLAGS : SEC_NLRI_LEN;
      end
      default: ;
    endcase
    if (eom_i) begin
      sec_d = SEC_HDR; pos_d = '0; srem_d = '0; atype_d = '0; long_len_d = 1'b0;
      arem_d = '0; acc_d = '0; fbl_d = '0; plen_d = '0; seg_left_d = '0;
      cnt_d = '0; ovf_d = 1'b0; phase_d = 2'd0; is_seq_d = 1'b0;
    end
  end

  always_comb begin
    rb = mk(KIND_END, '0, '0, '0);
    pair_o.a_vld = ra_v || eom_i;
    pair_o.a = ra_v ? ra : rb;
    pair_o.b_vld = ra_v && eom_i;
    pair_o.b = rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q <= SEC_HDR; pos_q <= '0; srem_q <= '0; atype_q <= '0; long_len_q <= 1'b0;
      arem_q <= '0; acc_q <= '0; fbl_q <= '0; plen_q <= '0; seg_left_q <= '0;
      cnt_q <= '0; ovf_q <= 1'b0; phase_q <= 2'd0; is_seq_q <= 1'b0;
    end else if (step_i) begin
      sec_q <= sec_d; pos_q <= pos_d; srem_q <= srem_d; atype_q <= atype_d;
      long_len_q <= long_len_d; arem_q <= arem_d; acc_q <= acc_d; fbl_q <= fbl_d;
      plen_q <= plen_d; seg_left_q <= seg_left_d; cnt_q <= cnt_d; ovf_q <= ovf_d;
      phase_q <= phase_d; is_seq_q <= is_seq_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MaxAsPath) else $error("as path count past limit");
  a_b_needs_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_o.b_vld |-> pair_o.a_vld) else $error("second record without first");
  a_eom_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eom_i |=> sec_q == SEC_HDR && cnt_q == '0) else $error("no clear at end");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/rump_back.sv -----
`default_nettype none
module rump_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire rump_pkg::pair_t pair_i,
  output logic             full_o,
  rump_out_if.source       out_o
);
  import rump_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  pair_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]  cnt_q, cnt_d;
  logic           sub_q;
  logic           pop_rec, pop_ent, push_ent;
  pair_t          head;

  always_comb begin
    head = mem_q[rp_q];
    push_ent = push_i && (pair_i.a_vld || pair_i.b_vld);
    out_o.valid = (cnt_q != '0);
    out_o.rec_kind = sub_q ? head.b.rec_kind : head.a.rec_kind;
    out_o.prefix_bits = sub_q ? head.b.prefix_bits : head.a.prefix_bits;
    out_o.field_value = sub_q ? head.b.field_value : head.a.field_value;
    out_o.path_index = sub_q ? head.b.path_index : head.a.path_index;
    out_o.last_of_run = sub_q || !head.b_vld;
    pop_rec = out_o.valid && out_o.ready;
    pop_ent = pop_rec && (sub_q || !head.b_vld);
    cnt_d = cnt_q + (push_ent ? 1'b1 : 1'b0) - (pop_ent ? 1'b1 : 1'b0);
    full_o = (cnt_q == (PtrW+1)'(QueueDepth));
  end

  always_ff @(posedge clk_i) begin
    if (push_ent) mem_q[wp_q] <= pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= 1'b0;
    end else begin
      if (push_ent) wp_q <= wp_q + 1'b1;
      if (pop_ent) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_d;
      if (pop_rec) sub_q <= !pop_ent;
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth)) else $error("queue overrun");
  a_sub_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> cnt_q != '0) else $error("second half with empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_ent) else $error("push into full queue");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/route_update_message_parser.sv -----
// UPDATE message parser.
// in_if carries one message byte per request plus end_of_message on the final
// byte; out_if carries result records (kind, prefix length, value, path
// index, last_of_run). Configuration: cfg_we_i writes cfg_wdata_i into
// four_octet_as (1: four-byte AS numbers, 0: two-byte); reset value 1.
// Throughput: one byte per cycle while the queue has space. The front decoder
// updates its counters and accumulator in the accept cycle and pushes up to
// two records as one entry into a four-entry queue; the back end drains one
// record per cycle while out_if.ready is high and offers the queue head on
// out_if. A byte that yields two records is offered as two records in turn,
// so a long burst of such bytes is paced by the output port.
// Reset clears the parser to header skip and empties the queue. When the
// receiver stalls, records collect in the queue; once it is full in_if.ready
// drops and bytes hold until space returns.
`default_nettype none
module route_update_message_parser #(
  parameter int unsigned MaxAsPath = rump_pkg::MaxAsPathDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  rump_in_if.sink    in_if,
  rump_out_if.source out_if
);
  import rump_pkg::*;

  logic  four_q;
  logic  full;
  logic  step;
  pair_t pair;

  assign in_if.ready = !full;
  assign step = in_if.valid && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) four_q <= 1'b1;
    else if (cfg_we_i) four_q <= cfg_wdata_i;
  end

  rump_front #(.MaxAsPath(MaxAsPath)) u_front (
    .clk_i, .rst_ni, .four_octet_as_i(four_q), .step_i(step),
    .byte_i(in_if.msg_byte), .eom_i(in_if.end_of_message), .pair_o(pair)
  );

  rump_back u_back (
    .clk_i, .rst_ni, .push_i(step), .pair_i(pair), .full_o(full), .out_o(out_if)
  );

endmodule
`default_nettype wire

// ----- verif/tb_route_update_message_parser.sv -----
`timescale 1ns / 100ps
module tb_route_update_message_parser;
  import rump_pkg::*;

  localparam int unsigned StallLimit = 3000;

  typedef struct {
    rec_kind_e   kind;
    logic [5:0]  bits;
    logic [31:0] val;
    logic [5:0]  idx;
    logic        last;
  } parsed_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  rump_in_if  in_if();
  rump_out_if out_if();

  route_update_message_parser u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  parsed_rec_t pending_recs[$];
  bit [7:0] msg_q[$];
  bit [7:0] sec_q[$];
  bit [7:0] body_q[$];

  int errors = 0;
  int checked = 0;
  int msgs_sent = 0;
  int body_bytes = 0;
  int bytes_sent = 0;
  int overflow_recs = 0;
  int bad_len_recs = 0;
  int idle_cycles = 0;
  bit rx_hold = 1'b0;
  bit tx_burst = 1'b0;
  parsed_rec_t got_exp;

  // parser state mirror
  logic        four_oct;
  logic [15:0] pos_cnt;
  section_e    sec;
  logic [15:0] sec_left;
  logic [7:0]  a_type;
  logic [7:0]  a_flags;
  logic [15:0] a_left;
  logic [31:0] acc;
  logic [2:0]  fbytes;
  logic [5:0]  plen;
  logic [7:0]  seg_left;
  logic [6:0]  as_cnt;
  logic        ovf_seen;
  logic [1:0]  seg_ph;
  logic        seg_seq;
  int          run_len;

  task automatic push_rec(input rec_kind_e kind, input logic [5:0] bits,
                          input logic [31:0] val, input logic [5:0] idx);
    parsed_rec_t r;
    r.kind = kind;
    r.bits = bits;
    r.val  = val;
    r.idx  = idx;
    r.last = 1'b0;
    pending_recs.push_back(r);
    run_len++;
  endtask

  task automatic clear_msg();
    pos_cnt = '0;
    sec = SEC_HDR;
    sec_left = '0;
    a_type = '0;
    a_flags = '0;
    a_left = '0;
    acc = '0;
    fbytes = '0;
    plen = '0;
    seg_left = '0;
    as_cnt = '0;
    ovf_seen = 1'b0;
    seg_ph = '0;
    seg_seq = 1'b0;
  endtask

  task automatic emit_prefix(input bit wd);
    int nb;
    logic [31:0] v;
    nb = (int'(plen) + 7) / 8;
    v = (nb != 0) ? (acc << (8 * (4 - nb))) : 32'd0;
    push_rec(wd ? KIND_WITHDRAWN : KIND_ANNOUNCED, plen, v, 6'd0);
    if (wd) sec = (sec_left == 0) ? SEC_ALEN_HI : SEC_WDR_LEN;
    else sec = SEC_NLRI_LEN;
  endtask

  task automatic start_prefix(input logic [7:0] len, input bit wd);
    if (len > 8'd32) begin
      sec = SEC_IDLE;
      push_rec(KIND_BAD_LEN, 6'd0, {24'd0, len}, 6'd0);
      return;
    end
    plen = len[5:0];
    acc = '0;
    fbytes = 3'((int'(len) + 7) / 8);
    if (fbytes == 0) emit_prefix(wd);
    else sec = wd ? SEC_WDR_BYTES : SEC_NLRI_BYTES;
  endtask

  task automatic attr_done();
    sec = (sec_left != 0) ? SEC_ATTR_FLAGS : SEC_NLRI_LEN;
  endtask

  task automatic as_path_byte(input logic [7:0] b);
    if (seg_ph == 0) begin
      seg_seq = (b == SegAsSequence);
      seg_ph = 2'd1;
    end else if (seg_ph == 1) begin
      seg_left = b;
      if (b != 0) begin
        seg_ph = 2'd2;
        fbytes = four_oct ? 3'd4 : 3'd2;
        acc = '0;
      end else begin
        seg_ph = 2'd0;
      end
    end else begin
      acc = (acc << 8) | b;
      if (fbytes != 0) fbytes--;
      if (fbytes == 0) begin
        if (seg_seq) begin
          if (as_cnt < MaxAsPathDefault) begin
            push_rec(KIND_AS_ELEM, 6'd0, acc, as_cnt[5:0]);
            as_cnt++;
          end else if (!ovf_seen) begin
            ovf_seen = 1'b1;
            push_rec(KIND_OVERFLOW, 6'd0, acc, 6'd0);
          end
        end
        seg_left--;
        acc = '0;
        if (seg_left == 0) seg_ph = 2'd0;
        else fbytes = four_oct ? 3'd4 : 3'd2;
      end
    end
  endtask

  task automatic attr_value_byte(input logic [7:0] b);
    if (a_type == AttrOrigin) begin
      if (fbytes != 0) begin
        fbytes = 3'd0;
        push_rec(KIND_ORIGIN, 6'd0, {24'd0, b}, 6'd0);
      end
    end else if (a_type == AttrAsPath) begin
      as_path_byte(b);
    end else if (a_type >= AttrNextHop && a_type <= AttrLocalPref) begin
      if (fbytes != 0) begin
        acc = (acc << 8) | b;
        fbytes--;
        if (fbytes == 0) push_rec(rec_kind_e'(a_type[3:0]), 6'd0, acc, 6'd0);
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eom);
    logic [15:0] pos;
    bit wd;
    pos = pos_cnt;
    run_len = 0;
    if (pos_cnt != 16'hFFFF) pos_cnt++;
    case (sec)
      SEC_HDR: begin
        if (pos >= HdrBytes - 1) sec = SEC_WLEN_HI;
      end
      SEC_WLEN_HI: begin
        sec_left = {b, 8'd0};
        sec = SEC_WLEN_LO;
      end
      SEC_WLEN_LO: begin
        sec_left |= b;
        sec = (sec_left != 0) ? SEC_WDR_LEN : SEC_ALEN_HI;
      end
      SEC_WDR_LEN: begin
        if (sec_left != 0) sec_left--;
        start_prefix(b, 1'b1);
      end
      SEC_WDR_BYTES, SEC_NLRI_BYTES: begin
        wd = (sec == SEC_WDR_BYTES);
        if (wd && sec_left != 0) sec_left--;
        acc = (acc << 8) | b;
        if (fbytes != 0) fbytes--;
        if (fbytes == 0) emit_prefix(wd);
      end
      SEC_ALEN_HI: begin
        sec_left = {b, 8'd0};
        sec = SEC_ALEN_LO;
      end
      SEC_ALEN_LO: begin
        sec_left |= b;
        sec = (sec_left != 0) ? SEC_ATTR_FLAGS : SEC_NLRI_LEN;
      end
      SEC_ATTR_FLAGS: begin
        if (sec_left != 0) sec_left--;
        a_flags = b;
        sec = SEC_ATTR_TYPE;
      end
      SEC_ATTR_TYPE: begin
        if (sec_left != 0) sec_left--;
        a_type = b;
        a_left = '0;
        sec = a_flags[4] ? SEC_ATTR_LEN_HI : SEC_ATTR_LEN_LO;
      end
      SEC_ATTR_LEN_HI: begin
        if (sec_left != 0) sec_left--;
        a_left = {b, 8'd0};
        sec = SEC_ATTR_LEN_LO;
      end
      SEC_ATTR_LEN_LO: begin
        if (sec_left != 0) sec_left--;
        a_left |= b;
        acc = '0;
        seg_ph = 2'd0;
        seg_left = '0;
        if (a_type == AttrOrigin) fbytes = 3'd1;
        else if (a_type >= AttrNextHop && a_type <= AttrLocalPref) fbytes = 3'd4;
        else fbytes = 3'd0;
        if (a_left == 0) attr_done();
        else sec = SEC_ATTR_VALUE;
      end
      SEC_ATTR_VALUE: begin
        if (sec_left != 0) sec_left--;
        a_left--;
        attr_value_byte(b);
        if (a_left == 0) attr_done();
      end
      SEC_NLRI_LEN: begin
        start_prefix(b, 1'b0);
      end
      default: begin
      end
    endcase
    if (eom) begin
      push_rec(KIND_END, 6'd0, 32'd0, 6'd0);
      clear_msg();
    end
    if (run_len > 0) pending_recs[pending_recs.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch on %s: got %0h, expected %0h (record %0d)", what, got, want, checked);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_recs.size() == 0) begin
        report_mismatch("unexpected record", {28'd0, out_if.rec_kind}, 32'd0);
      end else begin
        got_exp = pending_recs.pop_front();
        if (out_if.rec_kind !== got_exp.kind)
          report_mismatch("rec_kind", {28'd0, out_if.rec_kind}, {28'd0, got_exp.kind});
        if (out_if.prefix_bits !== got_exp.bits)
          report_mismatch("prefix_bits", {26'd0, out_if.prefix_bits}, {26'd0, got_exp.bits});
        if (out_if.field_value !== got_exp.val)
          report_mismatch("field_value", out_if.field_value, got_exp.val);
        if (out_if.path_index !== got_exp.idx)
          report_mismatch("path_index", {26'd0, out_if.path_index}, {26'd0, got_exp.idx});
        if (out_if.last_of_run !== got_exp.last)
          report_mismatch("last_of_run", {31'd0, out_if.last_of_run}, {31'd0, got_exp.last});
        if (got_exp.kind == KIND_OVERFLOW) overflow_recs++;
        if (got_exp.kind == KIND_BAD_LEN) bad_len_recs++;
      end
      checked++;
    end
  end

  always @(negedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("FAIL route_update_message_parser");
      $finish;
    end
  end

  int rx_wait = 0;
  always @(posedge clk_i) begin
    if (rx_hold) begin
      out_if.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 9) < 7) begin
      out_if.ready <= 1'b1;
    end else begin
      rx_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = 0;
    if (!tx_burst && $urandom_range(0, 9) >= 7)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.msg_byte <= b;
    in_if.end_of_message <= eom;
    do @(negedge clk_i); while (!in_if.ready);
    predict_byte(b, eom);
    bytes_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) begin
      send_byte(msg_q[i], i == msg_q.size() - 1);
      if (i >= HdrBytes) body_bytes++;
    end
    msgs_sent++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_as_width(input logic four);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= four;
    @(posedge clk_i);
    four_oct = four;
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_bytes(input bit [7:0] b[]);
    foreach (b[i]) msg_q.push_back(b[i]);
  endtask

  task automatic append_prefix(ref bit [7:0] q[$], input bit allow_bad);
    int r;
    int len;
    r = $urandom_range(0, 11);
    if (r == 0) len = 0;
    else if (r == 1) len = 32;
    else if (r == 2 && allow_bad) len = $urandom_range(33, 255);
    else len = $urandom_range(1, 32);
    q.push_back(8'(len));
    if (len <= 32) repeat ((len + 7) / 8) q.push_back(8'($urandom));
  endtask

  task automatic add_random_attr(ref bit [7:0] q[$]);
    int sel;
    int cnt;
    int w;
    bit ext;
    bit [7:0] atype;
    body_q.delete();
    sel = $urandom_range(0, 9);
    w = four_oct ? 4 : 2;
    if (sel <= 1) begin
      atype = AttrOrigin;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 1)
        body_q.push_back(8'($urandom));
    end else if (sel <= 4) begin
      atype = AttrAsPath;
      repeat ($urandom_range(0, 3)) begin
        body_q.push_back(($urandom_range(0, 3) != 0) ? SegAsSequence : 8'($urandom));
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 70) : $urandom_range(0, 5);
        body_q.push_back(8'(cnt));
        repeat (cnt * w) body_q.push_back(8'($urandom));
      end
      if (body_q.size() > 0 && $urandom_range(0, 5) == 0) void'(body_q.pop_back());
    end else if (sel <= 7) begin
      atype = 8'(sel - 2);
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4)
        body_q.push_back(8'($urandom));
    end else begin
      atype = 8'($urandom);
      repeat ($urandom_range(0, 4)) body_q.push_back(8'($urandom));
    end
    ext = (body_q.size() > 255) || ($urandom_range(0, 3) == 0);
    q.push_back((8'($urandom) & 8'hEF) | (ext ? 8'h10 : 8'h00));
    q.push_back(atype);
    if (ext) q.push_back(8'(body_q.size() >> 8));
    q.push_back(8'(body_q.size()));
    foreach (body_q[i]) q.push_back(body_q[i]);
  endtask

  task automatic push_section(input bit [15:0] len);
    if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(0, sec_q.size() + 3));
    msg_q.push_back(len[15:8]);
    msg_q.push_back(len[7:0]);
    foreach (sec_q[i]) msg_q.push_back(sec_q[i]);
  endtask

  task automatic build_random_msg();
    msg_q.delete();
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 40)) msg_q.push_back(8'($urandom));
      return;
    end
    repeat (HdrBytes) msg_q.push_back(8'($urandom));
    sec_q.delete();
    repeat ($urandom_range(0, 3)) append_prefix(sec_q, $urandom_range(0, 3) == 0);
    push_section(16'(sec_q.size()));
    sec_q.delete();
    repeat ($urandom_range(0, 5)) add_random_attr(sec_q);
    push_section(16'(sec_q.size()));
    repeat ($urandom_range(0, 3)) append_prefix(msg_q, $urandom_range(0, 3) == 0);
    if (msg_q.size() > 1 && $urandom_range(0, 7) == 0)
      msg_q = msg_q[0 : $urandom_range(0, msg_q.size() - 2)];
  endtask

  task automatic test_all_records();
    msg_q.delete();
    repeat (HdrBytes) msg_q.push_back(8'hFF);
    push_bytes('{8'h00, 8'h06, 8'h00, 8'h20, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'h00, 8'h27});
    push_bytes('{8'h40, 8'h01, 8'h01, 8'h02});
    push_bytes('{8'h50, 8'h03, 8'h00, 8'h04, 8'hC0, 8'hA8, 8'h00, 8'h01});
    push_bytes('{8'h80, 8'h04, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    push_bytes('{8'h40, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00});
    push_bytes('{8'h40, 8'h02, 8'h0A, 8'h02, 8'h02, 8'h00, 8'h00, 8'hFD, 8'hE8,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    push_bytes('{8'h18, 8'h0A, 8'h01, 8'h02, 8'h21, 8'h55});
    send_msg();
    wait_idle();
  endtask

  task automatic test_two_octet_and_short();
    write_as_width(1'b0);
    msg_q.delete();
    repeat (HdrBytes) msg_q.push_back(8'h00);
    push_bytes('{8'h00, 8'h00, 8'h00, 8'h14});
    push_bytes('{8'h40, 8'h02, 8'h08, 8'h01, 8'h01, 8'h00, 8'h10, 8'h02, 8'h01, 8'h12, 8'h34});
    push_bytes('{8'h40, 8'h04, 8'h02, 8'h11, 8'h22, 8'hC0, 8'h63, 8'h01, 8'h77});
    push_bytes('{8'h10, 8'hAB});
    send_msg();
    write_as_width(1'b1);
  endtask

  task automatic test_random_messages();
    while (bytes_sent < 500) begin
      if ($urandom_range(0, 3) == 0) write_as_width($urandom_range(0, 1));
      build_random_msg();
      send_msg();
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    tx_burst = 1'b1;
    fork
      begin
        @(negedge clk_i);
        rx_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      repeat (3) begin
        build_random_msg();
        send_msg();
      end
    join
    tx_burst = 1'b0;
    wait_idle();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.msg_byte = '0;
    in_if.end_of_message = 1'b0;
    out_if.ready = 1'b0;
    four_oct = 1'b1;
    clear_msg();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_all_records();
    test_two_octet_and_short();
    test_output_backpressure();
    test_random_messages();
    test_output_backpressure();
    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("ran %0d messages, %0d bytes (%0d past the header), %0d records checked",
             msgs_sent, bytes_sent, body_bytes, checked);
    $display("AS path overflow records: %0d, bad prefix length records: %0d",
             overflow_recs, bad_len_recs);
    if (errors == 0 && pending_recs.size() == 0) begin
      $display("PASS route_update_message_parser");
    end else begin
      $display("FAIL route_update_message_parser");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rump_pkg.sv
hw/rtl/rump_if.sv
hw/rtl/rump_front.sv
hw/rtl/rump_back.sv
hw/rtl/route_update_message_parser.sv
verif/tb_route_update_message_parser.sv
